/* hw/rtl/smmd_pkg.sv */
// Shared constants, types and the base64 digit table of the mappings decoder.
package smmd_pkg;

  localparam int unsigned POS_W     = 32;  // width of every running position
  localparam int unsigned NUM_POS   = 6;   // generated row and column, source, row, column, name
  localparam int unsigned NUM_DELTA = 5;   // deltas kept per segment
  localparam int unsigned PART_W    = POS_W + 1;  // sign bit plus magnitude
  localparam int unsigned DIGIT_W   = 7;   // six digit bits plus an invalid flag
  localparam int unsigned GROUP_W   = 5;   // payload bits per VLQ digit
  localparam int unsigned CNT_W     = 3;   // values seen in a segment, saturating
  localparam int unsigned SYM_W     = 8;

  localparam logic [SYM_W-1:0]   SymComma   = 8'h2C;
  localparam logic [SYM_W-1:0]   SymSemi    = 8'h3B;
  localparam logic [DIGIT_W-1:0] DigitBad   = 7'd64;
  localparam logic [CNT_W-1:0]   CntOne     = 3'd1;
  localparam logic [CNT_W-1:0]   CntFour    = 3'd4;
  localparam logic [CNT_W-1:0]   CntFive    = 3'd5;
  localparam logic [CNT_W-1:0]   CntSat     = 3'd6;

  localparam int unsigned DEFAULT_VALUE_BITS = 32;

  typedef logic [POS_W-1:0] pos_t;

  // Base64 alphabet to digit value; an invalid byte reads as DigitBad.
  function automatic logic [DIGIT_W-1:0] smmd_digit(input logic [SYM_W-1:0] sym);
    logic [DIGIT_W-1:0] d;
    d = DigitBad;
    if (sym >= 8'h41 && sym <= 8'h5A) begin
      d = DIGIT_W'(sym - 8'h41);
    end else if (sym >= 8'h61 && sym <= 8'h7A) begin
      d = DIGIT_W'(sym - 8'h61 + 8'd26);
    end else if (sym >= 8'h30 && sym <= 8'h39) begin
      d = DIGIT_W'(sym - 8'h30 + 8'd52);
    end else if (sym == 8'h2B) begin
      d = 7'd62;
    end else if (sym == 8'h2F) begin
      d = 7'd63;
    end
    return d;
  endfunction

endpackage

/* hw/rtl/source_map_mappings_decoder.sv */
// Source map mappings decoder: base64 VLQ text in, absolute position records out.
//
//  Channel  | Dir | Request contents
//  ---------+-----+------------------------------------------------------------
//  s_axis   | in  | tdata[7:0] symbol (one byte of mappings text); tlast last
//  m_axis   | out | tdata[191:0] gen_row, gen_column, source_index, orig_row,
//           |     | orig_column, name_index (32 bits each, lowest first);
//           |     | tuser error
//
// Each request is decoded combinationally: the digit table, the VLQ shift-or and
// one adder per running position sit between the state registers and the result
// register, so one request is taken per clock when the output side keeps up.
// A result is visible on the cycle after its request is accepted.
// The input is ready whenever the result register is empty or being emptied.
// Reset clears all decoding state and empties the result register; a request
// marked last returns the decoder to that same state once it has been processed.
module source_map_mappings_decoder
  import smmd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [SYM_W-1:0]       s_axis_tdata_i,   // [7:0] symbol
  input  logic                   s_axis_tlast_i,   // last
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [NUM_POS*POS_W-1:0] m_axis_tdata_o, // gen_row, gen_column, source_index,
                                                   // orig_row, orig_column, name_index
  output logic                   m_axis_tuser_o    // error
);

  // Longest legal VLQ value in digits, and the shift at which a further digit
  // is one too many.
  localparam int unsigned MaxDigits  = (VALUE_BITS + 4) / 5;
  localparam int unsigned ShiftLimit = GROUP_W * MaxDigits;
  localparam int unsigned SHIFT_W    = $clog2(ShiftLimit + 1);

  // Decoding state.
  pos_t                acc_q    [NUM_POS];
  pos_t                acc_d    [NUM_POS];
  pos_t                delta_q  [NUM_DELTA];
  pos_t                delta_d  [NUM_DELTA];
  logic [PART_W-1:0]   partial_q, partial_d;
  logic [SHIFT_W-1:0]  shift_q, shift_d;
  logic                cont_q, cont_d;
  logic [CNT_W-1:0]    nvals_q, nvals_d;
  logic                stopped_q, stopped_d;

  // Result register.
  pos_t                res_q    [NUM_POS];
  pos_t                res_d    [NUM_POS];
  logic                res_err_q, res_err_d;
  logic                out_valid_q;

  logic                in_acc;
  logic                res_load;

  // Per-request decode signals.
  logic [DIGIT_W-1:0]  digit;
  logic                is_comma, is_semi;
  logic [PART_W-1:0]   partial_new;
  logic [POS_W-1:0]    mag;
  logic                fin;
  logic                do_end;
  logic                err;
  logic                produce;
  pos_t                sum      [NUM_DELTA];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign res_load        = in_acc && produce;

  assign digit    = smmd_digit(s_axis_tdata_i);
  assign is_comma = (s_axis_tdata_i == SymComma);
  assign is_semi  = (s_axis_tdata_i == SymSemi);

  // The new digit's five payload bits land above those already gathered; bits
  // past the sign and the 32-bit magnitude never reach a result and fall away.
  assign partial_new = partial_q | (PART_W'(digit[GROUP_W-1:0]) << shift_q);
  assign mag         = partial_new[PART_W-1:1];

  // Segment sums. A value finished by this very request has not reached the
  // delta registers yet, so its magnitude is added or subtracted directly,
  // keeping one adder per running position.
  always_comb begin
    for (int k = 0; k < NUM_DELTA; k++) begin
      logic       use_new;
      logic       sub;
      logic [POS_W-1:0] op;
      use_new = fin && (nvals_q == CNT_W'(k));
      sub     = use_new && partial_new[0];
      op      = use_new ? mag : delta_q[k];
      sum[k]  = acc_q[k+1] + (op ^ {POS_W{sub}}) + POS_W'(sub);
    end
  end

  always_comb begin
    acc_d     = acc_q;
    delta_d   = delta_q;
    partial_d = partial_q;
    shift_d   = shift_q;
    cont_d    = cont_q;
    nvals_d   = nvals_q;
    stopped_d = stopped_q;
    res_d     = acc_q;
    res_err_d = 1'b0;
    fin       = 1'b0;
    do_end    = 1'b0;
    err       = 1'b0;
    produce   = 1'b0;

    if (!stopped_q) begin
      if (is_comma || is_semi) begin
        do_end = 1'b1;
      end else if (digit[DIGIT_W-1] || (shift_q >= SHIFT_W'(ShiftLimit))) begin
        // Not a base64 digit, or a value with one digit too many.
        err = 1'b1;
      end else if (digit[GROUP_W]) begin
        // Continuation digit: gather it and wait for the next one. On the last
        // character the segment still ends, with the value left dangling.
        partial_d = partial_new;
        cont_d    = 1'b1;
        shift_d   = shift_q + SHIFT_W'(GROUP_W);
        do_end    = s_axis_tlast_i;
      end else begin
        // Final digit of a value: fold the sign in and file it as a delta.
        fin       = 1'b1;
        cont_d    = 1'b0;
        partial_d = '0;
        shift_d   = '0;
        if (nvals_q < CntFive) begin
          delta_d[nvals_q] = partial_new[0] ? (POS_W'(0) - mag) : mag;
        end
        if (nvals_q != CntSat) begin
          nvals_d = nvals_q + CntOne;
        end
        do_end = s_axis_tlast_i;
      end

      if (do_end) begin
        if (cont_d) begin
          // The segment ends in the middle of a value.
          err = 1'b1;
        end else begin
          if (nvals_d == CntOne) begin
            acc_d[1] = sum[0];
          end else if (nvals_d >= CntFour) begin
            for (int k = 0; k < NUM_DELTA - 1; k++) begin
              acc_d[k+1] = sum[k];
            end
            if (nvals_d == CntFive) begin
              acc_d[NUM_POS-1] = sum[NUM_DELTA-1];
            end
            produce = 1'b1;
          end
          // The record carries the positions before any row change.
          res_d = acc_d;
          for (int k = 0; k < NUM_DELTA; k++) begin
            delta_d[k] = '0;
          end
          nvals_d = '0;
          if (is_semi) begin
            acc_d[0] = acc_q[0] + POS_W'(1);
            acc_d[1] = '0;
          end
        end
      end

      if (err) begin
        stopped_d = 1'b1;
        produce   = 1'b1;
        res_err_d = 1'b1;
        for (int k = 0; k < NUM_POS; k++) begin
          res_d[k] = '0;
        end
      end
    end

    // The last character of a text always leaves the decoder as after reset.
    if (s_axis_tlast_i) begin
      for (int k = 0; k < NUM_POS; k++) begin
        acc_d[k] = '0;
      end
      for (int k = 0; k < NUM_DELTA; k++) begin
        delta_d[k] = '0;
      end
      partial_d = '0;
      shift_d   = '0;
      cont_d    = 1'b0;
      nvals_d   = '0;
      stopped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_POS; k++) begin
        acc_q[k] <= '0;
      end
      for (int k = 0; k < NUM_DELTA; k++) begin
        delta_q[k] <= '0;
      end
      partial_q <= '0;
      shift_q   <= '0;
      cont_q    <= 1'b0;
      nvals_q   <= '0;
      stopped_q <= 1'b0;
    end else if (in_acc) begin
      acc_q     <= acc_d;
      delta_q   <= delta_d;
      partial_q <= partial_d;
      shift_q   <= shift_d;
      cont_q    <= cont_d;
      nvals_q   <= nvals_d;
      stopped_q <= stopped_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q     <= res_d;
      res_err_q <= res_err_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_err_q;
  always_comb begin
    for (int k = 0; k < NUM_POS; k++) begin
      m_axis_tdata_o[k*POS_W +: POS_W] = res_q[k];
    end
  end

  // An error result carries no positions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("error result with non-zero positions");

  // While stopped, every character taken, the last included, yields nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && stopped_q) |-> !res_load)
    else $error("result produced while decoding is stopped");

  // A last character leaves the decoder in its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=>
      (!stopped_q && !cont_q && (nvals_q == '0) && (shift_q == '0) && (acc_q[0] == '0)))
    else $error("state not cleared after last character");

  // The value count saturates and never passes six.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nvals_q <= CntSat)
    else $error("segment value count out of range");

endmodule
